FILE: rtl/gossip_membership_table_assert.svh
// Assertion macros for the gossip membership table.
// Clocked on i_clk and disabled while i_rst_n is low; empty under synthesis.
`ifndef GOSSIP_MEMBERSHIP_TABLE_ASSERT_SVH
`define GOSSIP_MEMBERSHIP_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
`define GMT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define GMT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define GMT_ASSERT(label, prop, msg)
`define GMT_NEVER(label, cond, msg)
`endif

`endif

FILE: rtl/gmt_pkg.sv
// Shared types and constants of the gossip membership table.
// Used by gmt_regs, gmt_ctrl, gmt_dp and the top level; no dependencies.
package gmt_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int ADDR_W          = 48;
    localparam int HB_W            = 32;
    localparam int TO_W            = 16;
    localparam int APB_AW          = 5;
    localparam int APB_DW          = 64;

    localparam logic [ADDR_W-1:0] OWN_ADDR_RST   = '0;
    localparam logic [TO_W-1:0]   FAIL_TO_RST    = 16'd5;
    localparam logic [TO_W-1:0]   CLEANUP_TO_RST = 16'd20;

    typedef enum logic [1:0] {
        ACT_MERGE = 2'd0,
        ACT_TICK  = 2'd1,
        ACT_READ  = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        KIND_UPDATED = 3'd0,
        KIND_ADDED   = 3'd1,
        KIND_IGNORED = 3'd2,
        KIND_FULL    = 3'd3,
        KIND_REMOVED = 3'd4,
        KIND_LISTED  = 3'd5,
        KIND_END     = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        REG_OWN_ADDR   = 2'd0,
        REG_FAIL_TO    = 2'd1,
        REG_CLEANUP_TO = 2'd2
    } t_reg;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_FIN  = 2'd2
    } t_state;

    typedef struct packed {
        logic [1:0]        action;
        logic [ADDR_W-1:0] entry_addr;
        logic [HB_W-1:0]   entry_heartbeat;
        logic              entry_failed;
    } t_item;

    typedef struct packed {
        t_kind             kind;
        logic [ADDR_W-1:0] out_addr;
        logic [HB_W-1:0]   out_heartbeat;
        logic              out_failed;
        logic              last;
    } t_result;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [HB_W-1:0]   heartbeat;
        logic [HB_W-1:0]   stamp;
        logic              failed;
    } t_entry;

    typedef struct packed {
        logic [ADDR_W-1:0] own_addr;
        logic [TO_W-1:0]   fail_timeout;
        logic [TO_W-1:0]   cleanup_timeout;
    } t_cfg;

    typedef struct packed {
        logic load_item;
        logic rd_en;
        logic ev_en;
        logic fin_en;
    } t_cmd;

    typedef struct packed {
        logic need_emit;
        logic hit;
        logic can_emit;
    } t_sts;

endpackage

FILE: rtl/gmt_regs.sv
// APB register bank: own address, fail timeout and cleanup timeout.
// Depends on gmt_pkg.
module gmt_regs import gmt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [ADDR_W-1:0] r_own_addr;
    logic [TO_W-1:0]   r_fail_to;
    logic [TO_W-1:0]   r_cleanup_to;
    t_reg              w_reg;
    logic              w_wr;

    assign pready = 1'b1;
    assign w_reg  = t_reg'(paddr[APB_AW-1:3]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_addr   <= OWN_ADDR_RST;
            r_fail_to    <= FAIL_TO_RST;
            r_cleanup_to <= CLEANUP_TO_RST;
        end else if (w_wr) begin
            case (w_reg)
                REG_OWN_ADDR:   r_own_addr   <= pwdata[ADDR_W-1:0];
                REG_FAIL_TO:    r_fail_to    <= pwdata[TO_W-1:0];
                REG_CLEANUP_TO: r_cleanup_to <= pwdata[TO_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            REG_OWN_ADDR:   prdata = {{(APB_DW-ADDR_W){1'b0}}, r_own_addr};
            REG_FAIL_TO:    prdata = {{(APB_DW-TO_W){1'b0}}, r_fail_to};
            REG_CLEANUP_TO: prdata = {{(APB_DW-TO_W){1'b0}}, r_cleanup_to};
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.own_addr        = r_own_addr;
    assign o_cfg.fail_timeout    = r_fail_to;
    assign o_cfg.cleanup_timeout = r_cleanup_to;

endmodule

FILE: rtl/gmt_ctrl.sv
// Controller: request acceptance and the slot scan sequencer.
// Depends on gmt_pkg; drives gmt_dp through t_cmd and reads t_sts back.
module gmt_ctrl import gmt_pkg::*; #(
    parameter  int TABLE_DEPTH = TABLE_DEPTH_DEF,
    localparam int IDX_W       = $clog2(TABLE_DEPTH),
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_in_action,
    output logic             o_in_stall,
    input  t_sts             i_sts,
    output t_cmd             o_cmd,
    output logic [IDX_W-1:0] o_rd_idx,
    output logic [IDX_W-1:0] o_ev_idx
);

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_rd_cnt, n_rd_cnt;
    logic              r_ev_valid, n_ev_valid;
    logic [IDX_W-1:0]  r_ev_idx, n_ev_idx;
    logic              w_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_rd_cnt   <= '0;
            r_ev_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_cnt   <= n_rd_cnt;
            r_ev_valid <= n_ev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ev_idx <= n_ev_idx;
    end

    always_comb begin
        n_state    = r_state;
        n_rd_cnt   = r_rd_cnt;
        n_ev_valid = r_ev_valid;
        n_ev_idx   = r_ev_idx;
        o_cmd      = '0;
        o_in_stall = (r_state != ST_IDLE);
        // hold the whole scan while a result waits for room
        w_go       = !(r_ev_valid && i_sts.need_emit && !i_sts.can_emit);
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_rd_cnt        = '0;
                    n_ev_valid      = 1'b0;
                    if ((i_in_action == ACT_MERGE) || (i_in_action == ACT_TICK) ||
                        (i_in_action == ACT_READ)) begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (w_go) begin
                    o_cmd.ev_en = r_ev_valid;
                    o_cmd.rd_en = (r_rd_cnt != DEPTH_CNT);
                    n_ev_valid  = o_cmd.rd_en;
                    n_ev_idx    = r_rd_cnt[IDX_W-1:0];
                    if (o_cmd.rd_en) begin
                        n_rd_cnt = r_rd_cnt + 1'b1;
                    end
                    if (r_ev_valid && i_sts.hit) begin
                        n_state = ST_IDLE;
                    end else if (!r_ev_valid && !o_cmd.rd_en) begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                if (i_sts.can_emit) begin
                    o_cmd.fin_en = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_rd_idx = r_rd_cnt[IDX_W-1:0];
    assign o_ev_idx = r_ev_idx;

endmodule

FILE: rtl/gmt_dp.sv
// Datapath: slot memory, valid bits, local clock, slot evaluation and result register.
// Depends on gmt_pkg and gossip_membership_table_assert.svh.
`include "gossip_membership_table_assert.svh"

module gmt_dp import gmt_pkg::*; #(
    parameter  int TABLE_DEPTH = TABLE_DEPTH_DEF,
    localparam int IDX_W       = $clog2(TABLE_DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_item            i_in,
    input  t_cfg             i_cfg,
    input  t_cmd             i_cmd,
    input  logic [IDX_W-1:0] i_rd_idx,
    input  logic [IDX_W-1:0] i_ev_idx,
    output t_sts             o_sts,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_result          o_out
);

    t_entry                 r_mem [TABLE_DEPTH];
    t_entry                 r_rdata;
    t_item                  r_item;
    logic [HB_W-1:0]        r_clock_now;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [IDX_W-1:0]       r_free_idx;
    logic                   r_free_found;
    t_result                r_out;
    logic                   r_out_valid;

    logic             w_can_emit, w_slot_valid;
    logic             w_is_merge, w_is_tick, w_is_read;
    logic             w_own, w_hit, w_hb_gt, w_remove, w_mark, w_bump, w_list;
    logic             w_take_free, w_insert, w_emit;
    logic [HB_W-1:0]  w_age;
    logic             w_wr_en;
    logic [IDX_W-1:0] w_wr_idx;
    t_entry           w_wr_data;
    t_result          w_res;

    assign w_can_emit   = !r_out_valid || !i_out_stall;
    assign w_slot_valid = r_valid[i_ev_idx];
    assign w_is_merge   = (r_item.action == ACT_MERGE);
    assign w_is_tick    = (r_item.action == ACT_TICK);
    assign w_is_read    = (r_item.action == ACT_READ);

    assign w_own   = (r_rdata.addr == i_cfg.own_addr);
    assign w_age   = r_clock_now - r_rdata.stamp;
    assign w_hb_gt = (r_item.entry_heartbeat > r_rdata.heartbeat);
    assign w_hit   = w_is_merge && w_slot_valid && (r_rdata.addr == r_item.entry_addr);
    assign w_bump  = w_is_tick && w_slot_valid && w_own;
    assign w_mark  = w_is_tick && w_slot_valid && !w_own && !r_rdata.failed &&
                     (w_age > HB_W'(i_cfg.fail_timeout));
    assign w_remove = w_is_tick && w_slot_valid && !w_own && r_rdata.failed &&
                      (w_age > HB_W'(i_cfg.cleanup_timeout));
    assign w_list   = w_is_read && w_slot_valid;

    assign w_take_free = i_cmd.ev_en && w_is_merge && !w_slot_valid && !r_free_found;
    assign w_insert    = i_cmd.fin_en && w_is_merge && !r_item.entry_failed && r_free_found;
    assign w_emit      = (i_cmd.ev_en && (w_hit || w_remove || w_list)) || i_cmd.fin_en;

    assign o_sts.need_emit = w_hit || w_remove || w_list;
    assign o_sts.hit       = w_hit;
    assign o_sts.can_emit  = w_can_emit;

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_idx  = i_ev_idx;
        w_wr_data = r_rdata;
        if (i_cmd.ev_en) begin
            if (w_hit && w_hb_gt) begin
                w_wr_en             = 1'b1;
                w_wr_data.heartbeat = r_item.entry_heartbeat;
                w_wr_data.stamp     = r_clock_now;
            end else if (w_bump) begin
                w_wr_en             = 1'b1;
                w_wr_data.heartbeat = r_rdata.heartbeat + 1'b1;
                w_wr_data.stamp     = r_clock_now;
            end else if (w_mark) begin
                w_wr_en          = 1'b1;
                w_wr_data.failed = 1'b1;
                w_wr_data.stamp  = r_clock_now;
            end
        end
        if (w_insert) begin
            w_wr_en             = 1'b1;
            w_wr_idx            = r_free_idx;
            w_wr_data.addr      = r_item.entry_addr;
            w_wr_data.heartbeat = r_item.entry_heartbeat;
            w_wr_data.stamp     = r_clock_now;
            w_wr_data.failed    = 1'b0;
        end
    end

    always_comb begin
        w_res = '{kind: KIND_END, out_addr: '0, out_heartbeat: '0, out_failed: 1'b0,
                  last: 1'b1};
        if (i_cmd.ev_en) begin
            w_res.out_addr      = r_rdata.addr;
            w_res.out_heartbeat = r_rdata.heartbeat;
            w_res.out_failed    = r_rdata.failed;
            w_res.last          = 1'b0;
            if (w_hit) begin
                w_res.kind = KIND_UPDATED;
                w_res.last = 1'b1;
                if (w_hb_gt) begin
                    w_res.out_heartbeat = r_item.entry_heartbeat;
                end
            end else if (w_remove) begin
                w_res.kind = KIND_REMOVED;
            end else begin
                w_res.kind = KIND_LISTED;
            end
        end else if (i_cmd.fin_en && w_is_merge) begin
            w_res.out_addr      = r_item.entry_addr;
            w_res.out_heartbeat = r_item.entry_heartbeat;
            if (r_item.entry_failed) begin
                w_res.kind       = KIND_IGNORED;
                w_res.out_failed = 1'b1;
            end else if (!r_free_found) begin
                w_res.kind = KIND_FULL;
            end else begin
                w_res.kind = KIND_ADDED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_now  <= '0;
            r_valid      <= '0;
            r_free_found <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.load_item && (i_in.action == ACT_TICK)) begin
                r_clock_now <= r_clock_now + 1'b1;
            end
            if (i_cmd.load_item) begin
                r_free_found <= 1'b0;
            end else if (w_take_free) begin
                r_free_found <= 1'b1;
            end
            if (w_insert) begin
                r_valid[r_free_idx] <= 1'b1;
            end
            if (i_cmd.ev_en && w_remove) begin
                r_valid[i_ev_idx] <= 1'b0;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in;
        end
        if (w_take_free) begin
            r_free_idx <= i_ev_idx;
        end
        if (w_emit) begin
            r_out <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_idx] <= w_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[i_rd_idx];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `GMT_NEVER(a_emit_room, w_emit && r_out_valid && i_out_stall, "result overwritten while stalled")
    `GMT_ASSERT(a_insert_free, w_insert |-> !r_valid[r_free_idx], "insert into occupied slot")
    `GMT_ASSERT(a_remove_valid, (i_cmd.ev_en && w_remove) |-> r_valid[i_ev_idx], "removal of empty slot")
    `GMT_NEVER(a_rw_clash, w_wr_en && i_cmd.rd_en && (w_wr_idx == i_rd_idx), "slot read while written")

endmodule

FILE: rtl/gossip_membership_table.sv
// Top level of the gossip membership table: heartbeat table with failure detection.
// Depends on gmt_pkg, gmt_regs, gmt_ctrl and gmt_dp.
//
//   channel   signals                          payload
//   in        i_in_valid / o_in_stall          t_item   (request)
//   out       o_out_valid / i_out_stall        t_result (one or more per merge, tick or read-out)
//   config    psel penable pwrite paddr pwdata 64-bit registers at 8*index
//
// A merge, tick or read-out keeps the input stalled until its slot scan and final step are
// done, so no new request is taken before the last is through; a merge that finds its
// address ends early, the cycle after that slot is looked at. The pace is set by the single
// read port of the slot memory, one slot per cycle while no result waits on a stalled output.
// Reset empties the table at once through the valid flops; no clearing pass.
// While a result waits on a stalled output the scan holds in place.
module gossip_membership_table import gmt_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_item             i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_result           o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    t_cfg             w_cfg;
    t_cmd             w_cmd;
    t_sts             w_sts;
    logic [IDX_W-1:0] w_rd_idx;
    logic [IDX_W-1:0] w_ev_idx;

    gmt_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    gmt_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_action (i_in.action),
        .o_in_stall  (o_in_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_rd_idx    (w_rd_idx),
        .o_ev_idx    (w_ev_idx)
    );

    gmt_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (w_cfg),
        .i_cmd       (w_cmd),
        .i_rd_idx    (w_rd_idx),
        .i_ev_idx    (w_ev_idx),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

FILE: sim/gossip_membership_table_tb.sv
// Self-checking testbench for gossip_membership_table: a directed script, then random
// merge, tick and read-out requests under several timeout settings, checked against a
// mirror of the table. Needs gmt_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module gossip_membership_table_tb import gmt_pkg::*;;

    localparam int DEPTH = TABLE_DEPTH_DEF;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int SETTLE = DEPTH + 8;

    typedef struct {
        bit      is_cfg;
        t_cfg    cfg;
        t_item   rq;
        bit      typed;
        t_result want;
    } t_step;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    t_item             i_in;
    logic              o_out_valid;
    logic              i_out_stall;
    t_result           o_out;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // mirror of the membership table
    logic              tbl_valid [DEPTH];
    logic [ADDR_W-1:0] tbl_addr  [DEPTH];
    logic [HB_W-1:0]   tbl_hb    [DEPTH];
    logic [HB_W-1:0]   tbl_stamp [DEPTH];
    logic              tbl_failed[DEPTH];
    logic [HB_W-1:0]   now_ticks;
    t_cfg              live_cfg;

    t_result           expected_results[$];
    t_step             script[$];
    logic [ADDR_W-1:0] addr_pool[22];

    int mismatches      = 0;
    int results_checked = 0;
    int settings_used   = 0;
    int hold_left       = 0;
    int run_left        = 0;
    bit hold_req        = 1'b0;

    gossip_membership_table #(.TABLE_DEPTH(DEPTH)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [ADDR_W-1:0] rand_addr48();
        return {16'($urandom()), $urandom()};
    endfunction

    function automatic t_item req(logic [1:0] act, logic [ADDR_W-1:0] addr,
                                  logic [HB_W-1:0] hb, logic fl);
        return '{act, addr, hb, fl};
    endfunction

    function automatic void add_req(t_item rq);
        script.push_back('{1'b0, '0, rq, 1'b0, '0});
    endfunction

    function automatic void add_typed(t_item rq, t_kind k, logic [ADDR_W-1:0] addr,
                                      logic [HB_W-1:0] hb, logic fl);
        script.push_back('{1'b0, '0, rq, 1'b1, '{k, addr, hb, fl, 1'b1}});
    endfunction

    function automatic void add_cfg(t_cfg c);
        script.push_back('{1'b1, c, '0, 1'b0, '0});
    endfunction

    function automatic void note_result(t_kind k, logic [ADDR_W-1:0] addr,
                                        logic [HB_W-1:0] hb, logic fl, logic lst);
        expected_results.push_back('{k, addr, hb, fl, lst});
    endfunction

    function automatic void reset_mirror();
        for (int i = 0; i < DEPTH; i++) begin
            tbl_valid[i] = 1'b0;
        end
        now_ticks = '0;
        live_cfg  = '{OWN_ADDR_RST, FAIL_TO_RST, CLEANUP_TO_RST};
    endfunction

    function automatic void predict_membership(t_item rq);
        int              slot_free;
        bit              found;
        logic [HB_W-1:0] age;
        case (rq.action)
            ACT_MERGE: begin
                slot_free = -1;
                found     = 1'b0;
                for (int i = 0; i < DEPTH; i++) begin
                    if (!found && tbl_valid[i] && tbl_addr[i] == rq.entry_addr) begin
                        found = 1'b1;
                        if (rq.entry_heartbeat > tbl_hb[i]) begin
                            tbl_hb[i]    = rq.entry_heartbeat;
                            tbl_stamp[i] = now_ticks;
                        end
                        note_result(KIND_UPDATED, tbl_addr[i], tbl_hb[i], tbl_failed[i], 1'b1);
                    end
                    if (!tbl_valid[i] && slot_free < 0) begin
                        slot_free = i;
                    end
                end
                if (!found) begin
                    if (rq.entry_failed) begin
                        note_result(KIND_IGNORED, rq.entry_addr, rq.entry_heartbeat, 1'b1, 1'b1);
                    end else if (slot_free < 0) begin
                        note_result(KIND_FULL, rq.entry_addr, rq.entry_heartbeat, 1'b0, 1'b1);
                    end else begin
                        tbl_valid[slot_free]  = 1'b1;
                        tbl_addr[slot_free]   = rq.entry_addr;
                        tbl_hb[slot_free]     = rq.entry_heartbeat;
                        tbl_stamp[slot_free]  = now_ticks;
                        tbl_failed[slot_free] = 1'b0;
                        note_result(KIND_ADDED, rq.entry_addr, rq.entry_heartbeat, 1'b0, 1'b1);
                    end
                end
            end
            ACT_TICK: begin
                now_ticks = now_ticks + 1'b1;
                for (int i = 0; i < DEPTH; i++) begin
                    if (!tbl_valid[i]) begin
                        continue;
                    end
                    if (tbl_addr[i] == live_cfg.own_addr) begin
                        tbl_hb[i]    = tbl_hb[i] + 1'b1;
                        tbl_stamp[i] = now_ticks;
                        continue;
                    end
                    age = now_ticks - tbl_stamp[i];
                    if (!tbl_failed[i]) begin
                        if (age > live_cfg.fail_timeout) begin
                            tbl_failed[i] = 1'b1;
                            tbl_stamp[i]  = now_ticks;
                        end
                    end else if (age > live_cfg.cleanup_timeout) begin
                        note_result(KIND_REMOVED, tbl_addr[i], tbl_hb[i], tbl_failed[i], 1'b0);
                        tbl_valid[i] = 1'b0;
                    end
                end
                note_result(KIND_END, '0, '0, 1'b0, 1'b1);
            end
            ACT_READ: begin
                for (int i = 0; i < DEPTH; i++) begin
                    if (tbl_valid[i]) begin
                        note_result(KIND_LISTED, tbl_addr[i], tbl_hb[i], tbl_failed[i], 1'b0);
                    end
                end
                note_result(KIND_END, '0, '0, 1'b0, 1'b1);
            end
            default: ;
        endcase
    endfunction

    function automatic t_item rand_req();
        t_item rq;
        int    r;
        r = $urandom_range(0, 99);
        if (r < 62) begin
            rq.action = ACT_MERGE;
        end else if (r < 88) begin
            rq.action = ACT_TICK;
        end else if (r < 97) begin
            rq.action = ACT_READ;
        end else begin
            rq.action = ACT_UNUSED;
        end
        if ($urandom_range(0, 99) < 85) begin
            rq.entry_addr = addr_pool[$urandom_range(0, 21)];
        end else begin
            rq.entry_addr = rand_addr48();
        end
        if ($urandom_range(0, 99) < 70) begin
            rq.entry_heartbeat = $urandom();
        end else begin
            rq.entry_heartbeat = $urandom_range(0, 64);
        end
        rq.entry_failed = ($urandom_range(0, 99) < 20);
        return rq;
    endfunction

    task automatic offer(t_item rq, bit typed, t_result want);
        int n0;
        i_in       <= rq;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        n0 = expected_results.size();
        predict_membership(rq);
        if (typed) begin
            while (expected_results.size() > n0) void'(expected_results.pop_back());
            expected_results.push_back(want);
        end
    endtask

    task automatic idle_gap();
        int r;
        int g;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            g = 0;
        end else if (r < 92) begin
            g = $urandom_range(1, 3);
        end else begin
            g = $urandom_range(8, 40);
        end
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic reg_write(t_reg r, logic [APB_DW-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 3'b000};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
    endtask

    // only while the block is idle: all results in, then its own latency
    task automatic write_settings(t_cfg c);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        reg_write(REG_OWN_ADDR, APB_DW'(c.own_addr));
        reg_write(REG_FAIL_TO, APB_DW'(c.fail_timeout));
        reg_write(REG_CLEANUP_TO, APB_DW'(c.cleanup_timeout));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        live_cfg = c;
        settings_used++;
    endtask

    function automatic void build_script();
        logic [ADDR_W-1:0] amax;
        logic [ADDR_W-1:0] odd;
        amax = '1;
        odd  = 48'hA5A5_5A5A_A5A5;
        add_typed(req(ACT_READ, '0, '0, 1'b0), KIND_END, '0, '0, 1'b0);
        add_typed(req(ACT_TICK, '0, '0, 1'b0), KIND_END, '0, '0, 1'b0);
        add_req(req(ACT_UNUSED, amax, '1, 1'b1));
        // address zero is the own address after reset
        add_typed(req(ACT_MERGE, '0, '0, 1'b0), KIND_ADDED, '0, '0, 1'b0);
        add_typed(req(ACT_MERGE, amax, '1, 1'b0), KIND_ADDED, amax, '1, 1'b0);
        add_req(req(ACT_MERGE, amax, 32'd5, 1'b0));
        add_typed(req(ACT_MERGE, odd, 32'h5A5A_A5A5, 1'b1), KIND_IGNORED, odd, 32'h5A5A_A5A5, 1'b1);
        add_req(req(ACT_MERGE, '0, 32'd7, 1'b1));
        for (int k = 1; k <= DEPTH - 2; k++) begin
            add_req(req(ACT_MERGE, 48'h0000_1000_0000 + k, 32'(k * 3), 1'b0));
        end
        add_typed(req(ACT_MERGE, 48'h5555_5555_5555, 32'hAAAA_AAAA, 1'b0),
                  KIND_FULL, 48'h5555_5555_5555, 32'hAAAA_AAAA, 1'b0);
        add_req(req(ACT_READ, '0, '0, 1'b0));
        // zero timeouts: first tick fails every other member, second removes them
        add_cfg('{amax, 16'd0, 16'd0});
        add_req(req(ACT_TICK, '0, '0, 1'b0));
        add_req(req(ACT_TICK, '0, '0, 1'b0));
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = 300;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= (hold_left != 0);
        end else if (run_left > 0) begin
            run_left--;
        end else if ($urandom_range(0, 99) < 10) begin
            run_left = $urandom_range(40, 120);
            i_out_stall <= 1'b0;
        end else if ($urandom_range(0, 99) < 5) begin
            run_left = $urandom_range(10, 40);
            i_out_stall <= 1'b1;
        end else begin
            run_left = $urandom_range(0, 3);
            i_out_stall <= ($urandom_range(0, 99) < 40);
        end
    end

    always @(posedge i_clk) begin
        t_result w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_checked++;
            if (expected_results.size() == 0) begin
                $error("unexpected result: kind %0d addr %0h", o_out.kind, o_out.out_addr);
                mismatches++;
            end else begin
                w = expected_results.pop_front();
                if (o_out.kind !== w.kind) begin
                    $error("kind: expected %0d, got %0d", w.kind, o_out.kind);
                    mismatches++;
                end
                if (o_out.out_addr !== w.out_addr) begin
                    $error("out_addr: expected %0h, got %0h", w.out_addr, o_out.out_addr);
                    mismatches++;
                end
                if (o_out.out_heartbeat !== w.out_heartbeat) begin
                    $error("out_heartbeat: expected %0h, got %0h",
                           w.out_heartbeat, o_out.out_heartbeat);
                    mismatches++;
                end
                if (o_out.out_failed !== w.out_failed) begin
                    $error("out_failed: expected %0b, got %0b", w.out_failed, o_out.out_failed);
                    mismatches++;
                end
                if (o_out.last !== w.last) begin
                    $error("last: expected %0b, got %0b", w.last, o_out.last);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $error("timeout with %0d results outstanding", expected_results.size());
        $display("Some tests failed");
        $finish;
    end

    initial begin
        t_cfg  phases[5];
        t_item rq;
        int    directed_cnt;
        int    random_cnt;
        int    count;
        bit    quiet;
        bit    held;
        directed_cnt = 0;
        random_cnt   = 0;
        held         = 1'b0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in       <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        for (int i = 0; i < 20; i++) begin
            addr_pool[i] = rand_addr48();
        end
        addr_pool[20] = '0;
        addr_pool[21] = '1;
        reset_mirror();
        build_script();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[s]) begin
            if (script[s].is_cfg) begin
                write_settings(script[s].cfg);
            end else begin
                offer(script[s].rq, script[s].typed, script[s].want);
                idle_gap();
                directed_cnt++;
            end
        end

        phases[0] = '{addr_pool[0], 16'd1, 16'd1};
        phases[1] = '{addr_pool[3], 16'd3, 16'd6};
        phases[2] = '{rand_addr48(), 16'hFFFF, 16'hFFFF};
        phases[3] = '{addr_pool[20], 16'd2, 16'hFFFF};
        phases[4] = '{addr_pool[1], 16'($urandom_range(1, 6)), 16'($urandom_range(1, 10))};
        for (int p = 0; p < 5; p++) begin
            write_settings(phases[p]);
            quiet = (p == 1);
            count = 0;
            while (count < 46) begin
                rq = rand_req();
                // long output hold-off while requests keep coming
                if (quiet && count == 10 && !held) begin
                    hold_req = 1'b1;
                    held     = 1'b1;
                end
                offer(rq, 1'b0, '0);
                if (!quiet) begin
                    idle_gap();
                end
                if (rq.action != ACT_UNUSED) begin
                    count++;
                    random_cnt++;
                end
            end
        end

        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        $display("Run covered %0d directed and %0d random requests over %0d register settings,",
                 directed_cnt, random_cnt, settings_used + 1);
        $display("with %0d results checked and %0d mismatches.", results_checked, mismatches);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
